@@ rtl/fgag_pkg.sv @@
// fgag_pkg: types, codes and constants of the font glyph address generator
// holds the input and result item structs, the result pair payload and the ascii lookup
// no dependencies
package fgag_pkg;

    // font modes
    localparam logic [2:0] OP_GB16 = 3'd0;
    localparam logic [2:0] OP_GB12 = 3'd1;
    localparam logic [2:0] OP_A16  = 3'd2;
    localparam logic [2:0] OP_A12  = 3'd3;
    localparam logic [2:0] OP_A7   = 3'd4;

    // result kinds
    localparam logic [1:0] KIND_ROM     = 2'd0;
    localparam logic [1:0] KIND_BUILTIN = 2'd1;
    localparam logic [1:0] KIND_MISS    = 2'd2;

    // built-in glyph selectors
    localparam logic [1:0] GLYPH_NONE  = 2'd0;
    localparam logic [1:0] GLYPH_G     = 2'd1;
    localparam logic [1:0] GLYPH_J     = 2'd2;
    localparam logic [1:0] GLYPH_UNDER = 2'd3;

    // rom layout
    localparam logic [23:0] BASE_GB16 = 24'h000000;
    localparam logic [23:0] BASE_GB12 = 24'h03CF80;
    localparam logic [23:0] BASE_A16  = 24'h03B7C0;
    localparam logic [23:0] BASE_A12  = 24'h066D40;
    localparam logic [23:0] BASE_A7   = 24'h03BFC0;

    localparam logic [6:0] ROW_LEN     = 7'd94;
    localparam logic [9:0] GB16_HZ_OFS = 10'd846;
    localparam logic [9:0] GB12_HZ_OFS = 10'd376;
    localparam logic [9:0] GB12_A9_OFS = 10'd282;

    localparam logic [5:0] SIZE_GB16 = 6'd32;
    localparam logic [5:0] SIZE_GB12 = 6'd24;
    localparam logic [5:0] SIZE_A16  = 6'd16;
    localparam logic [5:0] SIZE_A12  = 6'd12;
    localparam logic [5:0] SIZE_A7   = 6'd8;

    localparam logic [4:0] DEST_SECOND = 5'd16;

    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_TILDE = 8'h7E;
    localparam logic [7:0] CHR_G     = 8'h67;
    localparam logic [7:0] CHR_J     = 8'h6A;
    localparam logic [7:0] CHR_UNDER = 8'h5F;
    localparam logic [7:0] GB_LO_MIN = 8'hA1;

    typedef enum logic [1:0] {
        PATH_ROM,
        PATH_BUILTIN,
        PATH_PAIR,
        PATH_MISS
    } t_path;

    typedef struct packed {
        logic [2:0]  operation;
        logic [15:0] code;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [23:0] rom_address;
        logic [5:0]  byte_count;
        logic [1:0]  builtin_glyph;
        logic [4:0]  dest_offset;
        logic        last;
    } t_out_item;

    // one 8x16 ascii lookup
    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] glyph;
        logic [6:0] idx;
    } t_lookup;

    // two results of one item, second used only for a fallback pair
    typedef struct packed {
        t_out_item first;
        t_out_item second;
        logic      pair;
    } t_result_pair;

    localparam t_out_item MISS_ITEM = '{
        kind: KIND_MISS, rom_address: 24'd0, byte_count: 6'd0,
        builtin_glyph: GLYPH_NONE, dest_offset: 5'd0, last: 1'b1
    };

    function automatic logic is_printable(input logic [7:0] c);
        return (c >= CHR_SPACE) && (c <= CHR_TILDE);
    endfunction

    function automatic t_lookup ascii16_lookup(input logic [7:0] c);
        t_lookup lk;
        lk.kind  = KIND_ROM;
        lk.glyph = GLYPH_NONE;
        lk.idx   = 7'(c - CHR_SPACE);
        if (c == CHR_G) begin
            lk.kind  = KIND_BUILTIN;
            lk.glyph = GLYPH_G;
        end else if (c == CHR_J) begin
            lk.kind  = KIND_BUILTIN;
            lk.glyph = GLYPH_J;
        end else if (c == CHR_UNDER) begin
            lk.kind  = KIND_BUILTIN;
            lk.glyph = GLYPH_UNDER;
        end else if (!is_printable(c)) begin
            lk.kind = KIND_MISS;
        end
        return lk;
    endfunction

endpackage

@@ rtl/font_glyph_address_generator_core.sv @@
// font_glyph_address_generator_core: top level of the font rom glyph address generator
// decode, index and address stages, then the output register
// depends on fgag_pkg and fgag_out_stage
//
// Input channel: i_valid / o_stall / i_item carry a font mode and a character code.
// Output channel: o_valid / i_stall / o_result carry the rom read request of each
// result item: kind, byte address, byte count, built-in glyph, destination offset
// and a last flag on the final result of an item.
// One item enters per cycle while o_stall is low. An item whose GB2312 pair is
// unmapped and whose two bytes both resolve gives two results, the second offered
// in the cycle after the first is taken; until then the output register holds the
// second half and takes no new item.
// The four register stages are decode, row*94 index, index*size plus base, and the
// output register; each stage is filled whenever it is empty or moving on, so a
// stall at the output backs up stage by stage without losing or repeating an item.
// Synchronous reset empties all stages; no item is offered until one is accepted.
module font_glyph_address_generator_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  fgag_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output fgag_pkg::t_out_item o_result
);
    import fgag_pkg::*;

    typedef struct packed {
        t_path       path;
        logic [6:0]  row;
        logic [6:0]  col;
        logic [9:0]  offset;
        logic [5:0]  size;
        logic [23:0] base;
        logic [1:0]  glyph;
        t_lookup     hi_lk;
        t_lookup     lo_lk;
    } t_s1;

    typedef struct packed {
        t_path       path;
        logic [13:0] index;
        logic [5:0]  size;
        logic [23:0] base;
        logic [1:0]  glyph;
        t_lookup     hi_lk;
        t_lookup     lo_lk;
    } t_s2;

    logic         r_v1;
    logic         r_v2;
    logic         r_v3;
    t_s1          r_s1;
    t_s2          r_s2;
    t_result_pair r_s3;

    t_s1          n_s1;
    t_s2          n_s2;
    t_result_pair n_s3;

    logic en0;
    logic en1;
    logic en2;
    logic en3;

    assign en2     = !r_v3 || en3;
    assign en1     = !r_v2 || en2;
    assign en0     = !r_v1 || en1;
    assign o_stall = !en0;

    function automatic t_out_item half_item(input t_lookup lk, input logic second);
        t_out_item it;
        it.kind          = lk.kind;
        it.rom_address   = 24'd0;
        it.byte_count    = SIZE_A16;
        it.builtin_glyph = lk.glyph;
        it.dest_offset   = second ? DEST_SECOND : 5'd0;
        it.last          = second;
        if (lk.kind == KIND_ROM) begin
            it.rom_address = 24'({lk.idx, 4'b0000}) + BASE_A16;
        end
        return it;
    endfunction

    // decode
    always_comb begin
        logic [7:0] hi;
        logic [7:0] lo;
        logic       lo_ok;
        logic [6:0] col_gb;
        logic       fb_miss;

        hi      = i_item.code[15:8];
        lo      = i_item.code[7:0];
        lo_ok   = lo >= GB_LO_MIN;
        col_gb  = 7'(lo - GB_LO_MIN);

        n_s1.hi_lk  = ascii16_lookup(hi);
        n_s1.lo_lk  = ascii16_lookup(lo);
        n_s1.path   = PATH_MISS;
        n_s1.row    = 7'd0;
        n_s1.col    = 7'd0;
        n_s1.offset = 10'd0;
        n_s1.size   = 6'd0;
        n_s1.base   = 24'd0;
        n_s1.glyph  = GLYPH_NONE;

        fb_miss = (n_s1.hi_lk.kind == KIND_MISS) || (n_s1.lo_lk.kind == KIND_MISS);

        unique case (i_item.operation)
            OP_GB16: begin
                n_s1.size = SIZE_GB16;
                n_s1.base = BASE_GB16;
                if (hi >= 8'hA4 && hi <= 8'hA8 && lo_ok) begin
                    n_s1.path = PATH_ROM;
                end else if (hi >= 8'hA1 && hi <= 8'hA9 && lo_ok) begin
                    n_s1.path = PATH_ROM;
                    n_s1.row  = 7'(hi - 8'hA1);
                    n_s1.col  = col_gb;
                end else if (hi >= 8'hB0 && hi <= 8'hF7 && lo_ok) begin
                    n_s1.path   = PATH_ROM;
                    n_s1.row    = 7'(hi - 8'hB0);
                    n_s1.col    = col_gb;
                    n_s1.offset = GB16_HZ_OFS;
                end else begin
                    n_s1.path = fb_miss ? PATH_MISS : PATH_PAIR;
                end
            end
            OP_GB12: begin
                n_s1.size = SIZE_GB12;
                n_s1.base = BASE_GB12;
                if (hi >= 8'hA1 && hi <= 8'hA3 && lo_ok) begin
                    n_s1.path = PATH_ROM;
                    n_s1.row  = 7'(hi - 8'hA1);
                    n_s1.col  = col_gb;
                end else if (hi == 8'hA9 && lo_ok) begin
                    n_s1.path   = PATH_ROM;
                    n_s1.col    = col_gb;
                    n_s1.offset = GB12_A9_OFS;
                end else if (hi >= 8'hB0 && hi <= 8'hF7 && lo_ok) begin
                    n_s1.path   = PATH_ROM;
                    n_s1.row    = 7'(hi - 8'hB0);
                    n_s1.col    = col_gb;
                    n_s1.offset = GB12_HZ_OFS;
                end else begin
                    n_s1.path = fb_miss ? PATH_MISS : PATH_PAIR;
                end
            end
            OP_A16: begin
                n_s1.size  = SIZE_A16;
                n_s1.base  = BASE_A16;
                n_s1.col   = n_s1.lo_lk.idx;
                n_s1.glyph = n_s1.lo_lk.glyph;
                priority if (n_s1.lo_lk.kind == KIND_BUILTIN) begin
                    n_s1.path = PATH_BUILTIN;
                end else if (n_s1.lo_lk.kind == KIND_MISS) begin
                    n_s1.path = PATH_MISS;
                end else begin
                    n_s1.path = PATH_ROM;
                end
            end
            OP_A12: begin
                n_s1.size = SIZE_A12;
                n_s1.base = BASE_A12;
                n_s1.col  = 7'(lo - CHR_SPACE);
                n_s1.path = is_printable(lo) ? PATH_ROM : PATH_MISS;
            end
            OP_A7: begin
                n_s1.size = SIZE_A7;
                n_s1.base = BASE_A7;
                n_s1.col  = 7'(lo - CHR_SPACE);
                n_s1.path = is_printable(lo) ? PATH_ROM : PATH_MISS;
            end
            default: begin
                n_s1.path = PATH_MISS;
            end
        endcase
    end

    // glyph index
    always_comb begin
        n_s2.path  = r_s1.path;
        n_s2.index = 14'(14'(r_s1.row) * 14'(ROW_LEN)) + 14'(r_s1.col)
                   + 14'(r_s1.offset);
        n_s2.size  = r_s1.size;
        n_s2.base  = r_s1.base;
        n_s2.glyph = r_s1.glyph;
        n_s2.hi_lk = r_s1.hi_lk;
        n_s2.lo_lk = r_s1.lo_lk;
    end

    // byte address and result items
    always_comb begin
        logic [19:0] prod;

        prod        = 20'(20'(r_s2.index) * 20'(r_s2.size));
        n_s3.first  = MISS_ITEM;
        n_s3.second = MISS_ITEM;
        n_s3.pair   = 1'b0;

        unique case (r_s2.path)
            PATH_ROM: begin
                n_s3.first.kind        = KIND_ROM;
                n_s3.first.rom_address = 24'(prod) + r_s2.base;
                n_s3.first.byte_count  = r_s2.size;
            end
            PATH_BUILTIN: begin
                n_s3.first.kind          = KIND_BUILTIN;
                n_s3.first.byte_count    = SIZE_A16;
                n_s3.first.builtin_glyph = r_s2.glyph;
            end
            PATH_PAIR: begin
                n_s3.first  = half_item(r_s2.hi_lk, 1'b0);
                n_s3.second = half_item(r_s2.lo_lk, 1'b1);
                n_s3.pair   = 1'b1;
            end
            PATH_MISS: begin
                n_s3.first = MISS_ITEM;
            end
            default: begin
                n_s3.first = MISS_ITEM;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en0) begin
                r_v1 <= i_valid;
            end
            if (en1) begin
                r_v2 <= r_v1;
            end
            if (en2) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en0) begin
            r_s1 <= n_s1;
        end
        if (en1) begin
            r_s2 <= n_s2;
        end
        if (en2) begin
            r_s3 <= n_s3;
        end
    end

    fgag_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_v3),
        .i_pair   (r_s3),
        .o_ready  (en3),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (o_result)
    );

    a_first_half_followed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_result.last
        |=> o_valid && o_result.last && (o_result.dest_offset == DEST_SECOND))
        else $error("first half of a fallback pair not followed by its second half");

    a_not_rom_no_address: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_result.kind != KIND_ROM) |-> (o_result.rom_address == 24'd0))
        else $error("address given on a result that is not a rom read");

    a_miss_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_result.kind == KIND_MISS)
        |-> o_result.last && (o_result.byte_count == 6'd0))
        else $error("not-found result with a byte count or not last");

    a_stage3_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && !en3 |=> r_v3 && $stable(r_s3))
        else $error("address stage item lost while output is blocked");

endmodule

@@ rtl/fgag_out_stage.sv @@
// fgag_out_stage: output register of the glyph address pipeline
// splits a fallback pair into two result items, one per cycle while i_stall is low
// depends on fgag_pkg
module fgag_out_stage (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  fgag_pkg::t_result_pair i_pair,
    output logic                  o_ready,
    output logic                  o_valid,
    input  logic                  i_stall,
    output fgag_pkg::t_out_item   o_result
);
    import fgag_pkg::*;

    logic      r_valid;
    logic      r_pend;
    t_out_item r_res;
    t_out_item r_second;

    logic take;
    logic free;

    assign take    = r_valid && !i_stall;
    assign free    = !r_valid || (take && !r_pend);
    assign o_ready = free;
    assign o_valid = r_valid;
    assign o_result = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else if (take && r_pend) begin
            r_pend <= 1'b0;
        end else if (free) begin
            r_valid <= i_valid;
            r_pend  <= i_valid && i_pair.pair;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && r_pend) begin
            r_res <= r_second;
        end else if (free) begin
            r_res    <= i_pair.first;
            r_second <= i_pair.second;
        end
    end

endmodule
